>>> hdl/hemw_pkg.sv
// shared types and constants for the heightmap edge wall mesher
`default_nettype none

package hemw_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [2:0] LAST_VERT = 3'd5;

    // face ids after the near-side remap
    localparam logic [2:0] ID_FIXED_X_FAR  = 3'd1;
    localparam logic [2:0] ID_FIXED_Z_FAR  = 3'd2;
    localparam logic [2:0] ID_FIXED_X_NEAR = 3'd3;
    localparam logic [2:0] ID_FIXED_Z_NEAR = 3'd4;

    // per vertex order, bit v is vertex v; row is side ^ axis, row 1 in the upper slice
    localparam logic [1:0][5:0] VTX_TOP = {6'b100110, 6'b001011};
    localparam logic [1:0][5:0] VTX_FAR = {6'b110010, 6'b011010};

    typedef struct packed {
        logic       axis;
        logic       side;
        logic [7:0] fixed_coord;
        logic [7:0] top;
        logic [4:0] texture;
        logic [7:0] height;
        logic [7:0] near_end;
        logic [7:0] far_end;
        logic [7:0] tallest;
        logic       last;
    } face_t;

    typedef struct packed {
        logic [1:0] count;
        face_t      face_a;
        face_t      face_b;
    } push_t;

endpackage

`default_nettype wire

>>> hdl/hemw_front.sv
// front end: run detection per cell, produces up to two face descriptors
`default_nettype none

module hemw_front
    import hemw_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic       axis,
    input  wire logic       side,
    input  wire logic [7:0] fixed_coord,
    input  wire logic [7:0] cell_pos,
    input  wire logic [7:0] neighbor_height,
    input  wire logic [7:0] sector_top,
    input  wire logic [4:0] texture,
    input  wire logic       edge_end,
    output push_t           push
);

    logic       run_open_reg, run_open_next;
    logic [7:0] run_height_reg, run_height_next;
    logic [7:0] run_begin_reg, run_begin_next;
    logic [7:0] tallest_reg, tallest_next;

    logic [8:0] diff;
    logic       diff_pos, same;
    logic       face1, face2, open_mid, new_open, open_after;
    logic [7:0] h2, b2, tall1, tall2;
    face_t      f1, f2;

    always_comb begin
        diff     = {1'b0, sector_top} - {1'b0, neighbor_height};
        diff_pos = !diff[8] && (diff[7:0] != 8'd0);
        same     = !diff[8] && (diff[7:0] == run_height_reg);

        face1      = run_open_reg && !same;
        open_mid   = run_open_reg && same;
        new_open   = !open_mid && diff_pos;
        open_after = open_mid || new_open;
        face2      = edge_end && open_after;

        h2 = new_open ? diff[7:0] : run_height_reg;
        b2 = new_open ? cell_pos : run_begin_reg;

        tall1 = (face1 && run_height_reg > tallest_reg) ? run_height_reg : tallest_reg;
        tall2 = (face2 && h2 > tall1) ? h2 : tall1;

        f1.axis        = axis;
        f1.side        = side;
        f1.fixed_coord = fixed_coord;
        f1.top         = sector_top;
        f1.texture     = texture;
        f1.height      = run_height_reg;
        f1.near_end    = run_begin_reg;
        f1.far_end     = cell_pos;
        f1.tallest     = tall1;
        f1.last        = !face2;

        f2          = f1;
        f2.height   = h2;
        f2.near_end = b2;
        f2.far_end  = cell_pos + 8'd1;
        f2.tallest  = tall2;
        f2.last     = 1'b1;

        // compact so the first pushed entry is always face_a
        push.face_a = face1 ? f1 : f2;
        push.face_b = f2;
        push.count  = accept ? ({1'b0, face1} + {1'b0, face2}) : 2'd0;

        run_open_next   = run_open_reg;
        run_height_next = run_height_reg;
        run_begin_next  = run_begin_reg;
        tallest_next    = tallest_reg;
        if (accept) begin
            run_open_next   = open_after && !edge_end;
            run_height_next = h2;
            run_begin_next  = b2;
            tallest_next    = tall2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg   <= 1'b0;
            run_height_reg <= 8'd0;
            run_begin_reg  <= 8'd0;
            tallest_reg    <= 8'd0;
        end else begin
            run_open_reg   <= run_open_next;
            run_height_reg <= run_height_next;
            run_begin_reg  <= run_begin_next;
            tallest_reg    <= tallest_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hemw_queue.sv
// face descriptor queue, up to two writes and one read per cycle
`default_nettype none

module hemw_queue
    import hemw_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    input  wire logic  pop,
    output face_t      head,
    output logic       head_valid,
    output logic       has_room
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    face_t         mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;
    logic [PW-1:0] wr_ptr_b;

    always_comb begin
        wr_ptr_b    = wr_ptr_reg + PW'(1);
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push.count) - (PW+1)'(pop);
        head        = mem_reg[rd_ptr_reg];
        head_valid  = count_reg != '0;
        has_room    = count_reg <= (PW+1)'(QUEUE_DEPTH - 2);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.face_a;
        end
        if (push.count[1]) begin
            mem_reg[wr_ptr_b] <= push.face_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hemw_back.sv
// back end: expands each face into six vertices on the output register
`default_nettype none

module hemw_back
    import hemw_pkg::*;
#(
    parameter int COORD_WIDTH = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire face_t        head,
    input  wire logic         head_valid,
    output logic              pop,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);

    localparam logic [7:0] COORD_MASK =
        (COORD_WIDTH >= 8) ? 8'hFF : 8'((1 << COORD_WIDTH) - 1);

    logic        valid_reg, valid_next;
    logic [2:0]  vcnt_reg, vcnt_next;
    logic [39:0] data_reg, data_next;
    logic        last_reg, last_next;

    logic       load, row, use_top, use_far;
    logic [7:0] vary, fixed, y, x, z;
    logic [2:0] id;

    always_comb begin
        load    = head_valid && (!valid_reg || m_tready);
        pop     = load && (vcnt_reg == LAST_VERT);
        row     = head.side ^ head.axis;
        use_top = VTX_TOP[row][vcnt_reg];
        use_far = VTX_FAR[row][vcnt_reg];
        vary    = (use_far ? head.far_end : head.near_end) & COORD_MASK;
        fixed   = head.fixed_coord & COORD_MASK;
        y       = use_top ? head.top : head.top - head.height;
        x       = head.axis ? vary : fixed;
        z       = head.axis ? fixed : vary;

        unique case ({head.side, head.axis})
            2'b00:   id = ID_FIXED_X_FAR;
            2'b01:   id = ID_FIXED_Z_FAR;
            2'b10:   id = ID_FIXED_X_NEAR;
            default: id = ID_FIXED_Z_NEAR;
        endcase

        data_next  = data_reg;
        last_next  = last_reg;
        vcnt_next  = vcnt_reg;
        valid_next = valid_reg && !m_tready;
        if (load) begin
            data_next  = {head.tallest, head.texture, id, z, y, x};
            last_next  = head.last && (vcnt_reg == LAST_VERT);
            vcnt_next  = (vcnt_reg == LAST_VERT) ? 3'd0 : vcnt_reg + 3'd1;
            valid_next = 1'b1;
        end

        m_tvalid = valid_reg;
        m_tdata  = data_reg;
        m_tlast  = last_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            vcnt_reg  <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            vcnt_reg  <= vcnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/heightmap_edge_wall_mesher.sv
// top level of the heightmap edge wall mesher
// path: a face from a taken item is written to the face queue, then loaded into the output register behind m_tvalid
// throughput: one item per cycle while the face queue has room; each face is expanded into six
// output vertices, and the input stalls while the four-entry face queue has under two free slots
// reset: synchronous, active low; clears run state, tallest height, queue and output valid
`default_nettype none

module heightmap_edge_wall_mesher
    import hemw_pkg::*;
#(
    parameter int COORD_WIDTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fixed_coord, cell_pos, neighbor_height, sector_top, texture, zero pad
    input  wire logic [39:0] s_tdata,
    // axis, side
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // vert_x, vert_y, vert_z, face_word, tallest_seen
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);

    logic  accept, pop, head_valid, has_room;
    push_t push;
    face_t head;

    assign s_tready = has_room;
    assign accept   = s_tvalid && has_room;

    hemw_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .axis            (s_tuser[0]),
        .side            (s_tuser[1]),
        .fixed_coord     (s_tdata[7:0]),
        .cell_pos        (s_tdata[15:8]),
        .neighbor_height (s_tdata[23:16]),
        .sector_top      (s_tdata[31:24]),
        .texture         (s_tdata[36:32]),
        .edge_end        (s_tlast),
        .push            (push)
    );

    hemw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .has_room   (has_room)
    );

    hemw_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/hemw_checker.sv
// port-level checks for the mesher, bound to the top level
`default_nettype none

module hemw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // vertices of one item follow without gaps and tallest never drops inside it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[39:32] >= $past(m_tdata[39:32])))
        else $error("gap or tallest drop within one item's vertices");

    // face id is one of the four wall ids
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26:24] != 3'd0) && (m_tdata[26:24] <= 3'd4))
        else $error("bad face id");

endmodule

bind heightmap_edge_wall_mesher hemw_checker u_hemw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
